// File: hdl/forecast_driven_worker_governor_unit_defines.svh
// Assertion macros used by the governor checker.
`ifndef FORECAST_DRIVEN_WORKER_GOVERNOR_UNIT_DEFINES_SVH
`define FORECAST_DRIVEN_WORKER_GOVERNOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FGOV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("governor check failed");

// next-cycle implication, sampled on clk, off during rst
`define FGOV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("governor check failed");

`endif

// File: hdl/fgov_pkg.sv
// Types, codes and helpers for the worker governor.
`timescale 1ns / 1ps
package fgov_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THREADS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENALTY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TREND_GAIN  = 3'd4;

  localparam logic [1:0] FN_SAMPLE  = 2'd0;
  localparam logic [1:0] FN_EXIT    = 2'd1;
  localparam logic [1:0] FN_IO_DONE = 2'd2;
  localparam logic [1:0] FN_POLL    = 2'd3;

  localparam int          GAIN_W   = 17;
  localparam logic [16:0] GAIN_ONE = 17'd65536;

  typedef struct packed {
    logic [1:0]          func;
    logic signed [31:0]  level_delta;
    logic signed [15:0]  demand_hint;
  } fgov_in_t;

  typedef struct packed {
    logic                dispatch;
    logic                stop_request;
    logic [6:0]          active_workers;
    logic                end_signal;
    logic signed [31:0]  forecast;
  } fgov_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_LVL, ST_MUL_TRD, ST_FCAST, ST_DIV1, ST_DIV2, ST_DEC, ST_FIN
  } fgov_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sd2147483647) r = 32'sh7fffffff;
    else if (x < -36'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// File: hdl/fgov_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fgov_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qs;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, qs[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign quo   = qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      qs    <= num;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qs  <= {qs[NUM_W-2:0], ge};
    end
  end

endmodule

// File: hdl/forecast_driven_worker_governor_unit.sv
// Worker pool governor: Holt forecast of wait level driving dispatch/stop.
//
// Input channel in_valid/in_stall/in_data carries one item per beat:
// sample, worker exit, io complete or preempt poll. Every item returns one
// beat on out_valid/out_stall/out_data.
// Config: cfg_valid/cfg_ready with cfg_index/cfg_data; write only when idle.
// A non-sample item goes from idle to the final state, which writes its
// result to the output register. A sample after the first runs two
// 17-step serial multiplies (level and trend blends), then, unless end
// is set, two serial divisions of 33+FRAC_BITS steps each; the first
// sample after reset skips the multiplies.
// One item at a time: in_stall is high from accept until its result is
// written to the output register. A result waiting under out_stall does
// not block accepting the next item; that item holds in its last step
// until the output register frees.
// Reset (rst, synchronous) restores config defaults, clears the forecast
// state and sets one active worker.
`timescale 1ns / 1ps
module forecast_driven_worker_governor_unit import fgov_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int WORKER_LIMIT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fgov_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fgov_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int          NUM_W  = 33 + FRAC_BITS;
  localparam int          RATE_W = NUM_W + 2;
  localparam logic [31:0] TENTH  = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [6:0]  LIMIT  = 7'(WORKER_LIMIT);

  // configuration
  logic [6:0]  max_threads;
  logic [30:0] max_penalty;
  logic [30:0] min_rate;
  logic [16:0] level_gain;
  logic [16:0] trend_gain;

  // governor state
  logic signed [31:0] level, trend, prev, fcast;
  logic [1:0]         step;
  logic [31:0]        accw;
  logic [6:0]         wc;
  logic               stopf, endf;

  // per-item working registers
  fgov_state_t        state, state_next;
  logic [1:0]         func_r;
  logic signed [15:0] hint_r;
  logic signed [31:0] y_r, sp_r, bp_r;
  logic signed [32:0] z_r;
  logic signed [50:0] mcand, prod;
  logic [16:0]        mplier;
  logic [4:0]         mcnt;
  logic signed [NUM_W:0] r1, r2;
  logic               rate_ge;
  logic [31:0]        accw_sat;

  logic in_acc, fin_go, mul_busy, div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [31:0]      div_den;
  logic             div_neg, neg_r;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // control decode
  always_comb begin
    in_stall = (state != ST_IDLE);
    fin_go   = (state == ST_FIN) && (!out_valid || !out_stall);
    mul_busy = ((state == ST_MUL_LVL) || (state == ST_MUL_TRD)) && (mcnt != 5'(GAIN_W));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.func != FN_SAMPLE) state_next = ST_FIN;
          else if (step == 2'd0) state_next = ST_FCAST;
          else state_next = ST_MUL_LVL;
        end
      end
      ST_MUL_LVL: if (!mul_busy) state_next = ST_MUL_TRD;
      ST_MUL_TRD: if (!mul_busy) state_next = ST_FCAST;
      ST_FCAST:   state_next = endf ? ST_FIN : ST_DIV1;
      ST_DIV1:    if (div_done) state_next = ST_DIV2;
      ST_DIV2:    if (div_done) state_next = ST_DEC;
      ST_DEC:     state_next = ST_FIN;
      ST_FIN:     if (fin_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sample input: clamp new wait level to 0..2^31-1
  logic signed [32:0] ysum;
  logic signed [31:0] y_in;
  logic [1:0]         step_new;
  logic signed [31:0] bp_c;
  logic signed [32:0] z_c;
  logic [16:0]        a_cl, g_cl;

  assign ysum     = {in_data.level_delta[31], in_data.level_delta} + {prev[31], prev};
  assign y_in     = ysum[32] ? 32'sd0 : (ysum[31] ? 32'sh7fffffff : ysum[31:0]);
  assign step_new = (step == 2'd3) ? 2'd3 : step + 2'd1;
  assign bp_c     = (step_new == 2'd2) ? (y_in - prev) : trend;
  assign z_c      = {level[31], level} + {bp_c[31], bp_c};
  assign a_cl     = (level_gain > GAIN_ONE) ? GAIN_ONE : level_gain;
  assign g_cl     = (trend_gain > GAIN_ONE) ? GAIN_ONE : trend_gain;

  // blend = sat(z + floor((gain * d + 2^15) / 2^16))
  logic signed [50:0] rnd;
  logic signed [50:0] rsh;
  logic signed [31:0] blend_c;
  logic signed [33:0] d_trd;

  assign rnd     = prod + 51'sd32768;
  assign rsh     = rnd >>> 16;
  assign blend_c = sat32({{3{z_r[32]}}, z_r} + rsh[35:0]);
  assign d_trd   = {{2{blend_c[31]}}, blend_c} - {{2{sp_r[31]}}, sp_r}
                 - {{2{bp_r[31]}}, bp_r};

  // divider operand selection
  logic signed [32:0] dif1, dif2, dsel;
  logic [32:0]        dmag;

  assign dif1     = {y_r[31], y_r} - {prev[31], prev};
  assign dif2     = {fcast[31], fcast} - {y_r[31], y_r};
  assign dsel     = (state == ST_FCAST) ? dif1 : dif2;
  assign div_neg  = dsel[32];
  assign dmag     = dsel[32] ? 33'(-dsel) : dsel;
  assign div_num  = {dmag, {FRAC_BITS{1'b0}}};
  assign div_den  = ((state == ST_FCAST) ? prev : y_r) + TENTH;
  assign div_start = ((state == ST_FCAST) && !endf) || ((state == ST_DIV1) && div_done);

  fgov_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic signed [NUM_W:0] q_s;
  assign q_s = neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  // mean of the two rates, truncated toward zero
  logic signed [RATE_W-1:0] rsum, rhalf;
  logic [32:0]              accw_add;
  assign rsum     = {r1[NUM_W], r1} + {r2[NUM_W], r2};
  assign rhalf    = (rsum + $signed({{(RATE_W-1){1'b0}}, rsum[RATE_W-1]})) >>> 1;
  assign accw_add = {1'b0, accw} + {1'b0, y_r};

  // decision at commit
  logic signed [33:0] over_sum;
  logic               over, go, stop_set, hint_m1, hint_ge0, dec_en;
  logic [6:0]         lim;

  always_comb begin
    over_sum = {2'b00, accw_sat} + {{2{fcast[31]}}, fcast};
    over     = over_sum >= $signed({3'b000, max_penalty});
    hint_m1  = (hint_r == -16'sd1);
    hint_ge0 = !hint_r[15];
    dec_en   = (func_r == FN_SAMPLE) && !endf;
    lim      = (max_threads < LIMIT) ? max_threads : LIMIT;
    go       = 1'b0;
    stop_set = 1'b0;
    if (step <= 2'd1) begin
      go = over;
    end else if (hint_m1 && wc == 7'd0) begin
      go = 1'b1;
    end else if (hint_m1 && wc == 7'd1) begin
      go = rate_ge && over;
    end else if (hint_ge0) begin
      stop_set = !rate_ge && (wc > 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_threads <= 7'd4;
      max_penalty <= 31'd655360;
      min_rate    <= 31'd29491;
      level_gain  <= 17'd32768;
      trend_gain  <= 17'd52429;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_THREADS: max_threads <= cfg_data[6:0];
        CFG_MAX_PENALTY: max_penalty <= cfg_data;
        CFG_MIN_RATE:    min_rate    <= cfg_data;
        CFG_LEVEL_GAIN:  level_gain  <= cfg_data[16:0];
        CFG_TREND_GAIN:  trend_gain  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      trend     <= '0;
      prev      <= '0;
      fcast     <= '0;
      step      <= '0;
      accw      <= '0;
      wc        <= 7'd1;
      stopf     <= 1'b0;
      endf      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc && in_data.func == FN_SAMPLE) begin
        step <= step_new;
        if (step_new == 2'd1) level <= y_in;
      end
      if (state == ST_MUL_LVL && !mul_busy) level <= blend_c;
      if (state == ST_MUL_TRD && !mul_busy) trend <= blend_c;
      if (state == ST_FCAST) fcast <= sat32({{4{level[31]}}, level} + {{4{trend[31]}}, trend});

      out_valid <= fin_go || (out_valid && out_stall);
      if (fin_go) begin
        case (func_r)
          FN_SAMPLE: begin
            if (dec_en) begin
              prev <= y_r;
              if (go) begin
                stopf <= 1'b0;
                accw  <= '0;
                if (wc < lim) wc <= wc + 7'd1;
              end else begin
                accw <= accw_sat;
                if (stop_set) stopf <= 1'b1;
              end
            end
          end
          FN_EXIT: begin
            if (wc != 7'd0) wc <= wc - 7'd1;
            stopf <= 1'b0;
          end
          FN_IO_DONE: if (wc == 7'd1) endf <= 1'b1;
          FN_POLL:    stopf <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_data.func;
      hint_r <= in_data.demand_hint;
      y_r    <= y_in;
      sp_r   <= level;
      bp_r   <= bp_c;
      z_r    <= z_c;
      mcand  <= 51'($signed({{2{y_in[31]}}, y_in} - {z_c[32], z_c}));
      mplier <= a_cl;
      prod   <= '0;
      mcnt   <= '0;
    end else if (mul_busy) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      mcnt   <= mcnt + 5'd1;
    end else if (state == ST_MUL_LVL) begin
      z_r    <= {bp_r[31], bp_r};
      mcand  <= 51'(d_trd);
      mplier <= g_cl;
      prod   <= '0;
      mcnt   <= '0;
    end

    if (div_start) neg_r <= div_neg;
    if (state == ST_DIV1 && div_done) r1 <= q_s;
    if (state == ST_DIV2 && div_done) r2 <= q_s;
    if (state == ST_DEC) begin
      rate_ge  <= rhalf >= $signed(RATE_W'(min_rate));
      accw_sat <= accw_add[32] ? 32'hffffffff : accw_add[31:0];
    end

    if (fin_go) begin
      out_data.dispatch       <= dec_en && go && (wc < lim);
      out_data.stop_request   <= (func_r == FN_POLL) && stopf;
      out_data.end_signal     <= endf || ((func_r == FN_IO_DONE) && (wc == 7'd1));
      out_data.forecast       <= fcast;
      if (func_r == FN_SAMPLE)
        out_data.active_workers <= (dec_en && go && (wc < lim)) ? wc + 7'd1 : wc;
      else if (func_r == FN_EXIT)
        out_data.active_workers <= (wc != 7'd0) ? wc - 7'd1 : wc;
      else
        out_data.active_workers <= wc;
    end
  end

endmodule

// File: hdl/fgov_check.sv
// Port-level checker for the worker governor, bound to the top level.
`timescale 1ns / 1ps
`include "forecast_driven_worker_governor_unit_defines.svh"
module fgov_check import fgov_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input fgov_out_t out_data
);

  // a stalled result beat holds
  `FGOV_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // dispatch only on samples, stop only on polls: never both in one beat
  `FGOV_ASSERT_IMP(a_excl, out_valid, !(out_data.dispatch && out_data.stop_request))

  // one item at a time: an accepted beat closes the input
  `FGOV_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall)

  // no result beat right after reset
  `FGOV_ASSERT_IMP(a_rst_quiet, $past(rst), !out_valid)

endmodule

bind forecast_driven_worker_governor_unit fgov_check u_fgov_check (.*);
